// ===== rtl/assert_macros.svh =====
// Assertion helpers, sampled on the rising edge of clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a sampled edge.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/ial_pkg.sv =====
`timescale 1ns / 1ps

package ial_pkg;

    localparam logic [2:0] MODE_APPEND  = 3'd0;
    localparam logic [2:0] MODE_INSERT  = 3'd1;
    localparam logic [2:0] MODE_GET     = 3'd2;
    localparam logic [2:0] MODE_REMOVE  = 3'd3;
    localparam logic [2:0] MODE_REPLACE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_LOAD,
        ACT_INSERT,
        ACT_REMOVE
    } cell_act_t;

    typedef struct packed {
        cell_act_t act;
        logic      read_en;
    } cell_cmd_t;

endpackage

// ===== rtl/indexed_array_list.sv =====
// Indexed array list: an ordered list of up to DEPTH words with a live count.
// Command channel: mode, position and value are taken at a rising edge with
// start high and busy low. Modes: append, insert at index, get, remove at
// index, replace; other codes change nothing and report ok.
// Result channel: done is high for exactly one cycle, the cycle after the
// item is taken, with read_data (get only, else zero), status (ok, index out
// of range, list full) and entry_count (count after the item).
// One item is taken every cycle: each entry lives in
// its own cell, and all cells shift up, shift down or load in parallel by
// comparing their index with the target, so the whole list moves together.
// busy never rises. The receiver cannot stall; results are not held.
// Reset (rst_n low) empties the list and drops done; entry contents are not
// cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps

module indexed_array_list #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [5:0]  position,
    input  logic [31:0] value,
    output logic        done,
    output logic [31:0] read_data,
    output logic [1:0]  status,
    output logic [6:0]  entry_count
);
    import ial_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = CW + 6;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [DATA_W-1:0] rd_reg;

    logic              accept;
    logic              full;
    logic              in_range;
    logic              ins_ok;
    logic [CMPW-1:0]   pos_cmp;
    logic [CMPW-1:0]   cnt_cmp;
    logic [IW+5:0]     pos_wide;
    logic [IW-1:0]     pos_idx;
    logic [DATA_W+31:0] word_wide;
    logic [DATA_W-1:0] word;

    cell_cmd_t         cmd;
    logic [IW-1:0]     target;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_rd   [DEPTH];
    logic [DATA_W-1:0] rd_any;

    logic [DATA_W+31:0] rd_wide;
    logic [CW+6:0]      cnt_wide;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_cmp   = {{CW{1'b0}}, position};
    assign cnt_cmp   = {6'd0, count_reg};
    assign in_range  = (pos_cmp < cnt_cmp);
    assign ins_ok    = (pos_cmp <= cnt_cmp);
    assign full      = (count_reg == CW'(DEPTH));
    assign pos_wide  = {{IW{1'b0}}, position};
    assign pos_idx   = pos_wide[IW-1:0];
    assign word_wide = {{DATA_W{1'b0}}, value};
    assign word      = word_wide[DATA_W-1:0];

    // item decode: one command broadcast to every cell
    always_comb
    begin
        cmd.act     = ACT_HOLD;
        cmd.read_en = 1'b0;
        target      = pos_idx;
        status_next = ST_OK;
        count_next  = count_reg;
        if (accept)
        begin
            unique case (mode)
                MODE_APPEND:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.act    = ACT_LOAD;
                        target     = count_reg[IW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_INSERT:
                begin
                    if (!ins_ok)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.act    = ACT_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_GET:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.read_en = 1'b1;
                    end
                end
                MODE_REMOVE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.act    = ACT_REMOVE;
                        count_next = count_reg - CW'(1);
                    end
                end
                MODE_REPLACE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        cmd.act = ACT_LOAD;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_right
                assign right_d = cell_data[gi+1];
            end
            ial_cell #(
                .IDX    (gi),
                .IW     (IW),
                .DATA_W (DATA_W)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .target     (target),
                .word       (word),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .rd_data    (cell_rd[gi])
            );
        end
    endgenerate

    // at most one cell drives nonzero read data
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rd_reg     <= rd_any;
    end

    assign rd_wide     = {32'd0, rd_reg};
    assign cnt_wide    = {7'd0, count_reg};
    assign done        = done_reg;
    assign read_data   = rd_wide[31:0];
    assign status      = status_reg;
    assign entry_count = cnt_wide[6:0];

`include "assert_macros.svh"

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(DEPTH), "entry count above capacity")
    `ASSERT_CLK(a_done_follows, accept |=> done, "accepted item produced no result")
    `ASSERT_CLK(a_count_idle, !accept |=> $stable(count_reg), "count moved with no item")
    `ASSERT_NEVER(a_full_status, done && status == ST_FULL && count_reg != CW'(DEPTH),
        "full reported while list has room")

endmodule

// ===== rtl/ial_cell.sv =====
`timescale 1ns / 1ps

module ial_cell #(
    parameter int IDX    = 0,
    parameter int IW     = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  ial_pkg::cell_cmd_t cmd,
    input  logic [IW-1:0]     target,
    input  logic [DATA_W-1:0] word,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_data
);
    import ial_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;
    logic              above;

    assign hit   = (MY_IDX == target);
    assign above = (MY_IDX > target);

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.act)
            ACT_LOAD:
            begin
                if (hit)
                begin
                    data_next = word;
                end
            end
            ACT_INSERT:
            begin
                if (hit)
                begin
                    data_next = word;
                end
                else if (above)
                begin
                    data_next = left_data;
                end
            end
            ACT_REMOVE:
            begin
                if (hit || above)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (cmd.read_en && hit) ? data_reg : '0;

endmodule

// ===== bench/list_checker.sv =====
`timescale 1ns / 1ps

module list_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  mode,
    input  logic [5:0]  position,
    input  logic [31:0] value,
    input  logic        done,
    input  logic [31:0] read_data,
    input  logic [1:0]  status,
    input  logic [6:0]  entry_count,
    output int          fail_count,
    output int          pending,
    output logic [6:0]  list_len
);
    import ial_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [31:0] rd;
        logic [1:0]  st;
        logic [6:0]  cnt;
    } list_result_t;

    logic [31:0]  words [DEPTH];
    list_result_t expected_q [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // updates the shadow list and returns what the block should report
    task automatic apply_item(input logic [2:0] m, input logic [5:0] p,
                              input logic [31:0] v, output list_result_t res);
        int i;
        res = '0;
        res.st = ST_OK;
        case (m)
            MODE_APPEND:
            begin
                if (list_len >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    words[list_len[5:0]] = v;
                    list_len = list_len + 7'd1;
                end
            end
            MODE_INSERT:
            begin
                if (p > list_len)
                    res.st = ST_RANGE;
                else if (list_len >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        words[i] = words[i - 1];
                    words[p] = v;
                    list_len = list_len + 7'd1;
                end
            end
            MODE_GET:
            begin
                if (p >= list_len)
                    res.st = ST_RANGE;
                else
                    res.rd = words[p];
            end
            MODE_REMOVE:
            begin
                if (p >= list_len)
                    res.st = ST_RANGE;
                else
                begin
                    for (i = p; i + 1 < list_len; i++)
                        words[i] = words[i + 1];
                    list_len = list_len - 7'd1;
                end
            end
            MODE_REPLACE:
            begin
                if (p >= list_len)
                    res.st = ST_RANGE;
                else
                    words[p] = v;
            end
            default:
            begin
            end
        endcase
        res.cnt = list_len;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t fresh;
        if (!rst_n)
        begin
            list_len = '0;
            expected_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            // result of the previous item first, then the item taken at this edge
            if (done === 1'b1)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", read_data, '0);
                else
                begin
                    want = expected_q.pop_front();
                    if (read_data !== want.rd)
                        report_mismatch("read_data", read_data, want.rd);
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (entry_count !== want.cnt)
                        report_mismatch("entry_count", 32'(entry_count), 32'(want.cnt));
                end
            end
            if (start && !busy)
            begin
                apply_item(mode, position, value, fresh);
                expected_q.push_back(fresh);
            end
            pending = expected_q.size();
        end
    end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ial_pkg::*;

    localparam int          CYCLE_LIMIT   = 60000;
    localparam int          RANDOM_ITEMS  = 500;
    localparam int          DEPTH         = 64;
    localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  mode = '0;
    logic [5:0]  position = '0;
    logic [31:0] value = '0;
    logic        busy;
    logic        done;
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [6:0]  entry_count;

    int          fail_count;
    int          pending;
    logic [6:0]  list_len;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    indexed_array_list dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .position    (position),
        .value       (value),
        .done        (done),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count)
    );

    list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .position    (position),
        .value       (value),
        .done        (done),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count),
        .fail_count  (fail_count),
        .pending     (pending),
        .list_len    (list_len)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("indexed_array_list test failed");
            $finish;
        end
    end

    task automatic pause_random();
        int gap;
        if (!steady && $urandom_range(99) < 18)
        begin
            gap = $urandom_range(2, 1);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
    endtask

    // called at a falling edge; returns at the rising edge that takes the item
    task automatic send_item(input logic [2:0] m, input logic [5:0] p, input logic [31:0] v);
        bit taken;
        start    <= 1'b1;
        mode     <= m;
        position <= p;
        value    <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
    endtask

    task automatic issue(input logic [2:0] m, input logic [5:0] p, input logic [31:0] v);
        pause_random();
        @(negedge clk);
        send_item(m, p, v);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        bit          grow;
        int          r;
        int          span;
        logic [2:0]  m;
        logic [5:0]  p;
        logic [31:0] v;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // starting empty: indexed get, remove, replace are out of range
        issue(MODE_GET, 6'd0, 32'h1234_5678);
        issue(MODE_REMOVE, 6'd0, '0);
        issue(MODE_REPLACE, 6'd0, '1);
        issue(MODE_INSERT, 6'd1, 32'hDEAD_BEEF);
        issue(MODE_INSERT, 6'd0, '1);
        issue(MODE_APPEND, 6'd63, '0);
        issue(MODE_INSERT, 6'd2, 32'hA5A5_5A5A);
        issue(MODE_INSERT, 6'd1, 32'h5A5A_A5A5);
        issue(MODE_GET, 6'd0, '0);
        issue(MODE_GET, 6'd3, '0);
        issue(MODE_GET, 6'd4, '1);
        issue(MODE_GET, 6'd63, '0);
        issue(MODE_REPLACE, 6'd3, '1);
        issue(MODE_REPLACE, 6'd4, 32'h0F0F_0F0F);
        issue(MODE_GET, 6'd3, '0);
        issue(MODE_REMOVE, 6'd0, '0);
        issue(MODE_REMOVE, 6'd2, '0);
        issue(MODE_REMOVE, 6'd3, '0);
        for (int k = MODE_SPARE_LO; k <= MODE_SPARE_HI; k++)
            issue(3'(k), 6'($urandom_range(63)), $urandom());
        issue(MODE_GET, 6'd1, '0);
        drain();

        grow = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 150 && n < 250);
            if (n == 250 || $urandom_range(99) == 0)
                drain();
            pause_random();
            @(negedge clk);

            if (list_len == DEPTH && $urandom_range(9) == 0)
                grow = 1'b0;
            else if (list_len == 0 && $urandom_range(3) == 0)
                grow = 1'b1;

            r = $urandom_range(99);
            if (grow)
                m = (r < 35) ? MODE_APPEND : (r < 60) ? MODE_INSERT : (r < 75) ? MODE_GET :
                    (r < 83) ? MODE_REMOVE : (r < 95) ? MODE_REPLACE : MODE_SPARE_LO;
            else
                m = (r < 8) ? MODE_APPEND : (r < 16) ? MODE_INSERT : (r < 31) ? MODE_GET :
                    (r < 81) ? MODE_REMOVE : (r < 95) ? MODE_REPLACE : MODE_SPARE_LO;
            if (m == MODE_SPARE_LO)
                m = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));

            span = (m == MODE_INSERT) ? int'(list_len) : int'(list_len) - 1;
            if (span > DEPTH - 1)
                span = DEPTH - 1;
            r = $urandom_range(99);
            if (r < 15 || span < 0)
                p = 6'($urandom_range(63));
            else if (r < 25)
                p = 6'(span);
            else if (r < 30)
                p = '0;
            else
                p = 6'($urandom_range(span));

            r = $urandom_range(99);
            v = (r < 8) ? '0 : (r < 16) ? '1 : $urandom();

            send_item(m, p, v);
        end

        drain();
        repeat (3) @(posedge clk);
        if (fail_count == 0)
            $display("indexed_array_list test passed");
        else
            $display("indexed_array_list test failed");
        $finish;
    end
endmodule
